[src/gmsh_pkg.sv]
// Package: shared constants, state types, a hash step function for the string hasher.
package gmsh_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned PosW    = 8;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PosW-1:0]  MAX_SCAN   = 8'd255;
  localparam logic [7:0]       QUOTE_CHAR = 8'h22;
  localparam logic [7:0]       NUL_CHAR   = 8'h00;
  localparam logic [DataW-1:0] GROUP_INIT = 32'd1;

  localparam logic [CfgIdxW-1:0] REG_QUOTED_MODE = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_NO_HASH     = 1'd1;

  localparam logic [StatusW-1:0] ST_OK       = 2'd0;
  localparam logic [StatusW-1:0] ST_TOO_LONG = 2'd1;
  localparam logic [StatusW-1:0] ST_NO_QUOTE = 2'd2;

  typedef struct packed {
    logic [DataW-1:0] accumulator;
    logic [DataW-1:0] group_word;
    logic [PosW-1:0]  position;
    logic             active;
  } hash_state_t;

  typedef struct packed {
    logic               valid;
    logic [DataW-1:0]   hash_value;
    logic [StatusW-1:0] status;
  } hash_result_t;

  // x * 1610612741 mod 2^32; the constant is 2^30 + 2^29 + 2^2 + 1
  function automatic logic [DataW-1:0] mult_const(input logic [DataW-1:0] x);
    mult_const = (x << 30) + (x << 29) + (x << 2) + x;
  endfunction

endpackage

[src/gmsh_in_if.sv]
// Interface: input byte channel.
interface gmsh_in_if;
  logic       valid;
  logic       ready;
  logic       start_of_string;
  logic [7:0] byte_value;

  modport source (output valid, start_of_string, byte_value, input ready);
  modport sink   (input valid, start_of_string, byte_value, output ready);
endinterface

[src/gmsh_out_if.sv]
// Interface: hash result channel.
interface gmsh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] hash_value;
  logic [1:0]  status;

  modport source (output valid, hash_value, status, input ready);
  modport sink   (input valid, hash_value, status, output ready);
endinterface

[src/gmsh_cfg_if.sv]
// Interface: configuration register write channel.
interface gmsh_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/gmsh_step.sv]
// Combinational hash step: next state and optional result for one byte.
module gmsh_step (
  input  gmsh_pkg::hash_state_t              state,
  input  logic                               start_of_string,
  input  logic [7:0]                         byte_value,
  input  logic                               quoted_mode,
  input  logic [gmsh_pkg::DataW-1:0]         no_hash_value,
  output gmsh_pkg::hash_state_t              state_next,
  output gmsh_pkg::hash_result_t             result
);
  import gmsh_pkg::*;

  hash_state_t      s;
  logic [7:0]       term;
  logic [DataW-1:0] ext;
  logic [DataW-1:0] shifted;
  logic [DataW-1:0] gw_mix;
  logic [PosW-1:0]  pos_inc;

  always_comb begin
    s = state;
    if (start_of_string) begin
      s.accumulator = '0;
      s.group_word  = GROUP_INIT;
      s.position    = '0;
      s.active      = 1'b1;
    end
  end

  assign term = quoted_mode ? QUOTE_CHAR : NUL_CHAR;
  assign ext  = {{(DataW-8){byte_value[7]}}, byte_value};

  always_comb begin
    case (s.position[1:0])
      2'd0:    shifted = ext << 1;
      2'd1:    shifted = ext << 8;
      2'd2:    shifted = ext << 15;
      2'd3:    shifted = ext << 22;
      default: shifted = ext;
    endcase
  end

  assign gw_mix  = s.group_word ^ shifted;
  assign pos_inc = s.position + 8'd1;

  always_comb begin
    state_next        = s;
    result.valid      = 1'b0;
    result.hash_value = no_hash_value;
    result.status     = ST_OK;
    if (s.active) begin
      if (quoted_mode && s.position == '0) begin
        if (byte_value != QUOTE_CHAR) begin
          result.valid      = 1'b1;
          result.status     = ST_NO_QUOTE;
          state_next.active = 1'b0;
        end else begin
          state_next.position = 8'd1;
        end
      end else if (byte_value == term) begin
        result.valid      = 1'b1;
        result.hash_value = s.accumulator ^ s.group_word;
        state_next.active = 1'b0;
      end else begin
        state_next.position = pos_inc;
        if (pos_inc[1:0] == 2'd0) begin
          state_next.accumulator = mult_const(s.accumulator ^ gw_mix);
          state_next.group_word  = GROUP_INIT;
        end else begin
          state_next.group_word = gw_mix;
        end
        if (pos_inc >= MAX_SCAN) begin
          result.valid      = 1'b1;
          result.status     = ST_TOO_LONG;
          state_next.active = 1'b0;
        end
      end
    end
  end

endmodule

[src/grouped_multiply_string_hash.sv]
// Top level: grouped multiply string hasher, one byte per item.
//
// Usage:
//   req carries one string byte per item with start_of_string on the first byte.
//   rsp carries at most one result per byte: hash_value and status
//   (ok, string too long, missing opening quote). On error hash_value is the
//   no-hash register value. Bytes outside a string are dropped silently.
//   cfg writes register 0 (quoted mode) or 1 (no-hash value); always ready.
//   Write configuration only while no string result is pending.
// Timing:
//   An accepted byte sits in an input register, is hashed once the output
//   register is free and its result lands in the output register, which
//   drives rsp. One byte per cycle sustained while rsp does not stall; the
//   group multiply is a constant shift-add in the same cycle as the byte
//   merge.
// Reset:
//   rst (sync, active high) clears both stages, the hash state (idle) and the
//   configuration registers.
// Backpressure:
//   While rsp is stalled with a result held, the input stage holds its byte
//   and req.ready drops once that stage is full.
module grouped_multiply_string_hash (
  input  logic       clk,
  input  logic       rst,
  gmsh_in_if.sink    req,
  gmsh_out_if.source rsp,
  gmsh_cfg_if.sink   cfg
);
  import gmsh_pkg::*;

  logic             quoted_mode;
  logic [DataW-1:0] no_hash_value;

  logic       in_valid;
  logic       in_start;
  logic [7:0] in_byte;

  logic               out_valid;
  logic [DataW-1:0]   out_hash;
  logic [StatusW-1:0] out_status;

  hash_state_t  state;
  hash_state_t  state_next;
  hash_result_t result;

  logic out_free;
  logic advance;

  assign out_free  = !out_valid || rsp.ready;
  assign advance   = in_valid && out_free;
  assign req.ready = !in_valid || out_free;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      quoted_mode   <= 1'b0;
      no_hash_value <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_QUOTED_MODE: quoted_mode   <= cfg.data[0];
        REG_NO_HASH:     no_hash_value <= cfg.data;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.valid && req.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_start <= req.start_of_string;
      in_byte  <= req.byte_value;
    end
  end

  gmsh_step u_step (
    .state           (state),
    .start_of_string (in_start),
    .byte_value      (in_byte),
    .quoted_mode     (quoted_mode),
    .no_hash_value   (no_hash_value),
    .state_next      (state_next),
    .result          (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state.accumulator <= '0;
      state.group_word  <= GROUP_INIT;
      state.position    <= '0;
      state.active      <= 1'b0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && result.valid) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      out_hash   <= result.hash_value;
      out_status <= result.status;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.hash_value = out_hash;
  assign rsp.status     = out_status;

  a_status_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status == ST_OK || out_status == ST_TOO_LONG ||
                   out_status == ST_NO_QUOTE))
    else $error("illegal status code");

  a_error_hash: assert property (@(posedge clk) disable iff (rst)
    (advance && result.valid && result.status != ST_OK)
      |=> (out_hash == $past(no_hash_value)))
    else $error("error result without no-hash value");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    state.active |-> (state.position < MAX_SCAN))
    else $error("active string beyond scan limit");

  a_group_reset: assert property (@(posedge clk) disable iff (rst)
    (state.active && state.position[1:0] == 2'd0) |-> (state.group_word == GROUP_INIT))
    else $error("group word not reset at group boundary");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !out_free) |=> in_valid)
    else $error("stalled byte lost");

endmodule
